FILE: hw/rtl/ddf_pkg.sv
// ----------------------------------------------------------------------------
// Depth discontinuity filter package
// Shared types, constants and the neighbour distance check of the filter.
// ----------------------------------------------------------------------------
`default_nettype none

package ddf_pkg;

   localparam int DEPTH_BITS          = 24;
   localparam int SIZE_BITS           = 9;
   localparam int COL_OUT_BITS        = 8;
   localparam int ROW_OUT_BITS        = 8;
   localparam int CSR_INDEX_BITS      = 2;
   localparam int CSR_DATA_BITS       = 24;
   localparam int MAX_WIDTH_DEFAULT   = 256;
   localparam int MAX_HEIGHT_DEFAULT  = 256;

   typedef logic [DEPTH_BITS-1:0]   depth_code_type;
   typedef logic [SIZE_BITS-1:0]    frame_size_type;
   typedef logic [COL_OUT_BITS-1:0] pixel_column_type;
   typedef logic [ROW_OUT_BITS-1:0] pixel_row_type;

   localparam depth_code_type THRESHOLD_RESET = depth_code_type'(167772);
   localparam frame_size_type WIDTH_RESET     = frame_size_type'(200);
   localparam frame_size_type HEIGHT_RESET    = frame_size_type'(200);
   localparam depth_code_type FAR_CODE        = '1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_DEPTH_THRESHOLD = 2'd0,
      CSR_FRAME_WIDTH     = 2'd1,
      CSR_FRAME_HEIGHT    = 2'd2
   } csr_index_type;

   typedef struct packed {
      depth_code_type depth_code;
      logic           flush;
   } req_payload_type;

   typedef struct packed {
      pixel_column_type pixel_column;
      pixel_row_type    pixel_row;
      depth_code_type   pixel_depth;
   } rsp_payload_type;

   // Position and neighbour existence of the pixel judged by one beat.
   typedef struct packed {
      pixel_column_type column;
      pixel_row_type    row;
      logic             judge;
      logic             has_left;
      logic             has_right;
      logic             has_up;
      logic             has_down;
   } judge_tag_type;

   function automatic logic depth_near(input depth_code_type a, input depth_code_type b,
                                       input depth_code_type limit);
      depth_code_type diff;
      diff = (a > b) ? (a - b) : (b - a);
      return diff <= limit;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/depth_discontinuity_filter_core.sv
// ----------------------------------------------------------------------------
// Depth discontinuity filter core
// Streams a depth image in raster order and passes on each pixel whose depth
// is valid and close to all of its existing four neighbours.
//
// The request channel takes one depth code per beat, row by row, followed by
// one row of flush beats per frame. Flush beats inside an active row are
// taken and dropped. A pixel of row r is judged when the pixel below it, or
// the flush beat of its column, is taken; a passing pixel passes the judge
// stage and response registers to the response channel with its column, row
// and depth code. One beat is taken every cycle when not stalled; the line
// memory serves the lookahead and upper-neighbour reads and the write of
// each beat in the same cycle. When a result is held by a stalled receiver,
// the stage behind it keeps moving until it too holds a passing pixel; then
// the request side stalls. Reset empties the pipeline, restores the registers
// to their reset values and starts a new frame; no memory clearing is needed.
// A write of the frame width or height also restarts the frame.
// ----------------------------------------------------------------------------
`default_nettype none

module depth_discontinuity_filter_core #(
   parameter int MAX_WIDTH  = ddf_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = ddf_pkg::MAX_HEIGHT_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire ddf_pkg::req_payload_type            req_payload,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output ddf_pkg::rsp_payload_type                 rsp_payload,
   input  wire logic                                csr_write,
   input  wire logic [ddf_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [ddf_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   localparam int COL_BITS   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WID_BITS   = $clog2(MAX_WIDTH + 1);
   localparam int ROW_BITS   = $clog2(MAX_HEIGHT + 1);
   localparam int ADDR_BITS  = COL_BITS + 1;
   localparam int CMP_W_BITS = (ddf_pkg::SIZE_BITS > WID_BITS) ? ddf_pkg::SIZE_BITS : WID_BITS;
   localparam int CMP_H_BITS = (ddf_pkg::SIZE_BITS > ROW_BITS) ? ddf_pkg::SIZE_BITS : ROW_BITS;

   ddf_pkg::depth_code_type  threshold_ff;
   ddf_pkg::frame_size_type  width_ff;
   ddf_pkg::frame_size_type  height_ff;
   logic [COL_BITS-1:0]      col_ff;
   logic [COL_BITS-1:0]      col_in;
   logic [ROW_BITS-1:0]      row_ff;
   logic [ROW_BITS-1:0]      row_in;

   logic [CMP_W_BITS-1:0]    width_ext;
   logic [CMP_H_BITS-1:0]    height_ext;
   logic [WID_BITS-1:0]      width_eff;
   logic [ROW_BITS-1:0]      height_eff;
   logic [WID_BITS-1:0]      col_plus;
   logic [ROW_BITS-1:0]      row_minus;
   logic                     last_col;
   logic                     active;
   logic                     take;
   logic                     step;
   logic                     judge_ready;
   logic [ADDR_BITS-1:0]     addr_a;
   logic [ADDR_BITS-1:0]     addr_b;
   ddf_pkg::depth_code_type  rd_a;
   ddf_pkg::depth_code_type  rd_b;
   ddf_pkg::judge_tag_type   tag;

   always_comb begin
      width_ext  = CMP_W_BITS'(width_ff);
      height_ext = CMP_H_BITS'(height_ff);
      if (width_ext == '0) begin
         width_eff = WID_BITS'(1);
      end else if (width_ext > CMP_W_BITS'(MAX_WIDTH)) begin
         width_eff = WID_BITS'(MAX_WIDTH);
      end else begin
         width_eff = WID_BITS'(width_ext);
      end
      if (height_ext == '0) begin
         height_eff = ROW_BITS'(1);
      end else if (height_ext > CMP_H_BITS'(MAX_HEIGHT)) begin
         height_eff = ROW_BITS'(MAX_HEIGHT);
      end else begin
         height_eff = ROW_BITS'(height_ext);
      end
   end

   always_comb begin
      col_plus  = WID_BITS'(col_ff) + WID_BITS'(1);
      row_minus = row_ff - ROW_BITS'(1);
      last_col  = (col_plus == width_eff);
      active    = (row_ff < height_eff);
      req_stall = !judge_ready;
      take      = req_valid && judge_ready;
      step      = take && !(active && req_payload.flush);

      // At the end of a row the lookahead port fetches the first pixel of the
      // row just written, which is the first centre of the next row's pass.
      if (last_col) begin
         addr_a = {row_ff[0], COL_BITS'(0)};
      end else begin
         addr_a = {~row_ff[0], col_plus[COL_BITS-1:0]};
      end
      addr_b = {row_ff[0], col_ff};

      tag.column    = ddf_pkg::pixel_column_type'(col_ff);
      tag.row       = ddf_pkg::pixel_row_type'(row_minus);
      tag.judge     = (row_ff != '0);
      tag.has_left  = (col_ff != '0);
      tag.has_right = !last_col;
      tag.has_up    = (row_ff > ROW_BITS'(1));
      tag.has_down  = active;

      col_in = col_ff;
      row_in = row_ff;
      if (step) begin
         if (last_col) begin
            col_in = '0;
            row_in = (row_ff == height_eff) ? '0 : (row_ff + ROW_BITS'(1));
         end else begin
            col_in = col_plus[COL_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= ddf_pkg::THRESHOLD_RESET;
         width_ff     <= ddf_pkg::WIDTH_RESET;
         height_ff    <= ddf_pkg::HEIGHT_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
      end else if (csr_write) begin
         case (csr_index)
            ddf_pkg::CSR_DEPTH_THRESHOLD: begin
               threshold_ff <= ddf_pkg::depth_code_type'(csr_data);
            end
            ddf_pkg::CSR_FRAME_WIDTH: begin
               width_ff <= ddf_pkg::frame_size_type'(csr_data);
               col_ff   <= '0;
               row_ff   <= '0;
            end
            ddf_pkg::CSR_FRAME_HEIGHT: begin
               height_ff <= ddf_pkg::frame_size_type'(csr_data);
               col_ff    <= '0;
               row_ff    <= '0;
            end
            default: begin
               col_ff <= col_in;
               row_ff <= row_in;
            end
         endcase
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   ddf_line_mem #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_mem (
      .clock   (clock),
      .rd_en   (step),
      .addr_a  (addr_a),
      .addr_b  (addr_b),
      .wr_en   (step && active),
      .wr_data (req_payload.depth_code),
      .rd_a    (rd_a),
      .rd_b    (rd_b)
   );

   ddf_judge u_judge (
      .clock       (clock),
      .reset       (reset),
      .enter       (step),
      .tag         (tag),
      .down        (req_payload.depth_code),
      .rd_a        (rd_a),
      .rd_b        (rd_b),
      .threshold   (threshold_ff),
      .ready       (judge_ready),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

FILE: hw/rtl/ddf_line_mem.sv
// ----------------------------------------------------------------------------
// Depth discontinuity filter line memory
// Two line buffers in one array, selected by row parity. Two registered read
// ports and one write port; the write port reads its old contents first.
// ----------------------------------------------------------------------------
`default_nettype none

module ddf_line_mem #(
   parameter int  MAX_WIDTH = ddf_pkg::MAX_WIDTH_DEFAULT,
   localparam int COL_BITS  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
   localparam int ADDR_BITS = COL_BITS + 1
) (
   input  wire logic                   clock,
   input  wire logic                   rd_en,
   input  wire logic [ADDR_BITS-1:0]   addr_a,
   input  wire logic [ADDR_BITS-1:0]   addr_b,
   input  wire logic                   wr_en,
   input  wire ddf_pkg::depth_code_type wr_data,
   output ddf_pkg::depth_code_type     rd_a,
   output ddf_pkg::depth_code_type     rd_b
);

   localparam int MEM_DEPTH = 2 ** ADDR_BITS;

   ddf_pkg::depth_code_type line_mem_ff [MEM_DEPTH];
   ddf_pkg::depth_code_type rd_a_ff;
   ddf_pkg::depth_code_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem_ff[addr_b] <= wr_data;
      end
      if (rd_en) begin
         // With a one-pixel row the prefetch targets the entry being written.
         if (wr_en && (addr_a == addr_b)) begin
            rd_a_ff <= wr_data;
         end else begin
            rd_a_ff <= line_mem_ff[addr_a];
         end
         rd_b_ff <= line_mem_ff[addr_b];
      end
   end

   assign rd_a = rd_a_ff;
   assign rd_b = rd_b_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/ddf_judge.sv
// ----------------------------------------------------------------------------
// Depth discontinuity filter judge stage
// Holds the centre and left window, compares the centre pixel with its four
// neighbours and drives the registered result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module ddf_judge (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    enter,
   input  wire ddf_pkg::judge_tag_type  tag,
   input  wire ddf_pkg::depth_code_type down,
   input  wire ddf_pkg::depth_code_type rd_a,
   input  wire ddf_pkg::depth_code_type rd_b,
   input  wire ddf_pkg::depth_code_type threshold,
   output logic                         ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output ddf_pkg::rsp_payload_type     rsp_payload
);

   logic                      s1_valid_ff;
   ddf_pkg::judge_tag_type    s1_tag_ff;
   ddf_pkg::depth_code_type   s1_down_ff;
   ddf_pkg::depth_code_type   centre_ff;
   ddf_pkg::depth_code_type   left_ff;
   logic                      rsp_valid_ff;
   ddf_pkg::rsp_payload_type  rsp_payload_ff;
   logic                      s1_emit;
   logic                      s1_advance;

   always_comb begin
      s1_emit = s1_valid_ff && s1_tag_ff.judge
                && (centre_ff != '0) && (centre_ff != ddf_pkg::FAR_CODE)
                && (!s1_tag_ff.has_left  || ddf_pkg::depth_near(centre_ff, left_ff, threshold))
                && (!s1_tag_ff.has_right || ddf_pkg::depth_near(centre_ff, rd_a, threshold))
                && (!s1_tag_ff.has_up    || ddf_pkg::depth_near(centre_ff, rd_b, threshold))
                && (!s1_tag_ff.has_down  || ddf_pkg::depth_near(centre_ff, s1_down_ff, threshold));
      s1_advance = !s1_emit || !rsp_valid_ff || !rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (enter) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   // The previous beat's lookahead read is this beat's centre pixel.
   always_ff @(posedge clock) begin
      if (enter) begin
         s1_tag_ff  <= tag;
         s1_down_ff <= down;
         centre_ff  <= rd_a;
         left_ff    <= centre_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_emit && s1_advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_emit && s1_advance) begin
         rsp_payload_ff.pixel_column <= s1_tag_ff.column;
         rsp_payload_ff.pixel_row    <= s1_tag_ff.row;
         rsp_payload_ff.pixel_depth  <= centre_ff;
      end
   end

   assign ready       = !s1_valid_ff || s1_advance;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// Depth discontinuity filter core testbench
// Streams depth frames through the core under a series of threshold and frame
// size settings. A predictor written alongside the stimulus works out which
// pixels survive the four-neighbour check. The monitor compares every
// response beat with the oldest predicted pixel. The request channel idles
// and the response channel stalls at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int BEAT_TARGET   = 1950;
   localparam int SETTLE_CYCLES = 8;
   localparam int REPORT_LIMIT  = 10;
   localparam int LINE_SLOTS    = ddf_pkg::MAX_WIDTH_DEFAULT;
   localparam int ROW_LIMIT     = ddf_pkg::MAX_HEIGHT_DEFAULT;

   typedef logic [ddf_pkg::CSR_DATA_BITS-1:0] csr_word_type;

   logic                               clock       = 1'b0;
   logic                               reset       = 1'b1;
   logic                               req_valid   = 1'b0;
   logic                               req_stall;
   ddf_pkg::req_payload_type           req_payload = '0;
   logic                               rsp_valid;
   logic                               rsp_stall   = 1'b0;
   ddf_pkg::rsp_payload_type           rsp_payload;
   logic                               csr_write   = 1'b0;
   logic [ddf_pkg::CSR_INDEX_BITS-1:0] csr_index   = ddf_pkg::CSR_DEPTH_THRESHOLD;
   csr_word_type                       csr_data    = '0;

   ddf_pkg::depth_code_type  thr_cfg    = ddf_pkg::THRESHOLD_RESET;
   ddf_pkg::frame_size_type  width_cfg  = ddf_pkg::WIDTH_RESET;
   ddf_pkg::frame_size_type  height_cfg = ddf_pkg::HEIGHT_RESET;
   ddf_pkg::depth_code_type  line_buf [0:2*LINE_SLOTS-1] = '{default: '0};
   int                       col_count  = 0;
   int                       row_count  = 0;

   ddf_pkg::rsp_payload_type expected_pixels [$];
   ddf_pkg::req_payload_type pending_beats [$];

   int gen_col        = 0;
   int gen_row        = 0;
   int beats_counted  = 0;
   int pixels_checked = 0;
   int mismatches     = 0;
   int phase_count    = 0;
   int cycle_count    = 0;
   int req_idle       = 0;
   int req_quiet      = 0;
   int stall_left     = 0;
   int open_left      = 0;
   int rsp_quiet      = 0;

   depth_discontinuity_filter_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int active_width();
      if (width_cfg == 0) return 1;
      if (width_cfg > LINE_SLOTS) return LINE_SLOTS;
      return int'(width_cfg);
   endfunction

   function automatic int active_height();
      if (height_cfg == 0) return 1;
      if (height_cfg > ROW_LIMIT) return ROW_LIMIT;
      return int'(height_cfg);
   endfunction

   function automatic void step_position(inout int col, inout int row);
      col++;
      if (col >= active_width()) begin
         col = 0;
         row++;
         if (row > active_height()) row = 0;
      end
   endfunction

   function automatic int buf_slot(int row, int col);
      return (row % 2) * LINE_SLOTS + col;
   endfunction

   function automatic bit depths_agree(ddf_pkg::depth_code_type a,
                                       ddf_pkg::depth_code_type b);
      ddf_pkg::depth_code_type gap;
      gap = (a > b) ? a - b : b - a;
      return gap <= thr_cfg;
   endfunction

   function automatic bit pixel_survives(int col, int row, int width, bit has_below,
                                         ddf_pkg::depth_code_type below);
      ddf_pkg::depth_code_type centre;
      bit                      ok;
      centre = line_buf[buf_slot(row, col)];
      ok = (centre != '0) && (centre != ddf_pkg::FAR_CODE);
      if (col >= 1 && !depths_agree(centre, line_buf[buf_slot(row, col - 1)])) ok = 1'b0;
      if (col + 1 < width && !depths_agree(centre, line_buf[buf_slot(row, col + 1)]))
         ok = 1'b0;
      if (row >= 1 && !depths_agree(centre, line_buf[buf_slot(row - 1, col)])) ok = 1'b0;
      if (has_below && !depths_agree(centre, below)) ok = 1'b0;
      return ok;
   endfunction

   // The pixel above the current position is judged as a depth beat arrives in
   // an active row; in the flush row it is judged without a lower neighbour.
   function automatic void predict_beat(ddf_pkg::req_payload_type beat);
      int width;
      int height;
      int col;
      int row;
      bit survives;
      width    = active_width();
      height   = active_height();
      col      = col_count;
      row      = row_count;
      survives = 1'b0;
      if (row < height) begin
         if (beat.flush) return;
         if (row >= 1) survives = pixel_survives(col, row - 1, width, 1'b1, beat.depth_code);
         line_buf[buf_slot(row, col)] = beat.depth_code;
      end else begin
         survives = pixel_survives(col, row - 1, width, 1'b0, '0);
      end
      if (survives)
         expected_pixels.push_back('{pixel_column: ddf_pkg::pixel_column_type'(col),
                                     pixel_row:    ddf_pkg::pixel_row_type'(row - 1),
                                     pixel_depth:  line_buf[buf_slot(row - 1, col)]});
      step_position(col, row);
      col_count = col;
      row_count = row;
   endfunction

   function automatic void check_pixel(ddf_pkg::rsp_payload_type got);
      ddf_pkg::rsp_payload_type want;
      pixels_checked++;
      if (expected_pixels.size() == 0) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("Unexpected pixel: column %0d row %0d depth 0x%06h",
                     got.pixel_column, got.pixel_row, got.pixel_depth);
         return;
      end
      want = expected_pixels.pop_front();
      if (got.pixel_column !== want.pixel_column || got.pixel_row !== want.pixel_row ||
          got.pixel_depth !== want.pixel_depth) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display({"Pixel mismatch: expected col %0d row %0d depth 0x%06h,",
                      " got col %0d row %0d depth 0x%06h"},
                     want.pixel_column, want.pixel_row, want.pixel_depth,
                     got.pixel_column, got.pixel_row, got.pixel_depth);
      end
   endfunction

   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(11, 40);
   endfunction

   function automatic ddf_pkg::depth_code_type pick_threshold();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return ddf_pkg::FAR_CODE;
         2: return ddf_pkg::depth_code_type'($urandom_range(0, 300));
         3: return ddf_pkg::depth_code_type'($urandom);
         4: return ddf_pkg::THRESHOLD_RESET;
         default: return ddf_pkg::depth_code_type'($urandom_range(1000, 100000));
      endcase
   endfunction

   function automatic int pick_spread();
      int limit;
      int far_limit;
      limit     = int'(thr_cfg);
      far_limit = int'(ddf_pkg::FAR_CODE);
      case ($urandom_range(0, 4))
         0: return 0;
         1: return limit;
         2: return limit / 2;
         3: return (2 * limit + 1 > far_limit) ? far_limit : 2 * limit + 1;
         default: return $urandom_range(0, far_limit);
      endcase
   endfunction

   function automatic ddf_pkg::depth_code_type scene_depth(longint base, int spread);
      longint value;
      case ($urandom_range(0, 63))
         0: return '0;
         1: return ddf_pkg::FAR_CODE;
         2: return ddf_pkg::depth_code_type'($urandom);
         3: return ($urandom_range(0, 1) != 0) ? ddf_pkg::FAR_CODE - 1 :
                                                 ddf_pkg::depth_code_type'(1);
         default: begin
            value = base + longint'($urandom_range(0, spread));
            if (value > longint'(ddf_pkg::FAR_CODE)) value = longint'(ddf_pkg::FAR_CODE);
            return ddf_pkg::depth_code_type'(value);
         end
      endcase
   endfunction

   task automatic queue_beat(ddf_pkg::depth_code_type depth, logic is_flush);
      pending_beats.push_back('{depth_code: depth, flush: is_flush});
      if (!is_flush || gen_row >= active_height()) begin
         beats_counted++;
         step_position(gen_col, gen_row);
      end
   endtask

   // Mostly well-formed raster data around a random base, with stray flush
   // beats in active rows and depth beats in the flush row as noise.
   task automatic queue_scene(int count, int spread);
      longint base;
      int     n;
      base = longint'($urandom_range(0, int'(ddf_pkg::FAR_CODE)));
      n    = 0;
      while (n < count) begin
         if (gen_row < active_height()) begin
            if ($urandom_range(0, 31) == 0) begin
               queue_beat(ddf_pkg::depth_code_type'($urandom), 1'b1);
            end else begin
               queue_beat(scene_depth(base, spread), 1'b0);
               n++;
            end
         end else begin
            queue_beat(ddf_pkg::depth_code_type'($urandom), ($urandom_range(0, 6) != 0));
            n++;
         end
      end
   endtask

   task automatic write_register(ddf_pkg::csr_index_type index, csr_word_type value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      case (index)
         ddf_pkg::CSR_DEPTH_THRESHOLD: thr_cfg = ddf_pkg::depth_code_type'(value);
         ddf_pkg::CSR_FRAME_WIDTH: begin
            width_cfg = ddf_pkg::frame_size_type'(value);
            col_count = 0;
            row_count = 0;
            gen_col   = 0;
            gen_row   = 0;
         end
         ddf_pkg::CSR_FRAME_HEIGHT: begin
            height_cfg = ddf_pkg::frame_size_type'(value);
            col_count  = 0;
            row_count  = 0;
            gen_col    = 0;
            gen_row    = 0;
         end
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      while (pending_beats.size() != 0 || req_valid || expected_pixels.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_idle  <= 0;
         req_quiet <= 0;
      end else begin
         if (req_valid && !req_stall) predict_beat(req_payload);
         if (req_quiet > 0) req_quiet <= req_quiet - 1;
         else if ($urandom_range(0, 60) == 0) req_quiet <= $urandom_range(20, 120);
         if (!req_valid || !req_stall) begin
            if (req_idle > 0) begin
               req_valid <= 1'b0;
               req_idle  <= req_idle - 1;
            end else if (pending_beats.size() != 0) begin
               req_valid   <= 1'b1;
               req_payload <= pending_beats.pop_front();
               req_idle    <= (req_quiet > 0) ? 0 : idle_length();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
         open_left  <= 0;
         rsp_quiet  <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) check_pixel(rsp_payload);
         if (rsp_quiet > 0) rsp_quiet <= rsp_quiet - 1;
         else if ($urandom_range(0, 60) == 0) rsp_quiet <= $urandom_range(20, 120);
         if (stall_left > 0 && rsp_quiet == 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= stall_left - 1;
         end else if (open_left > 0) begin
            rsp_stall <= 1'b0;
            open_left <= open_left - 1;
         end else begin
            rsp_stall  <= 1'b0;
            stall_left <= idle_length();
            open_left  <= $urandom_range(0, 6);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d pixels outstanding.",
                  cycle_count, expected_pixels.size());
         $display("tb_top: FAIL");
         $finish;
      end
   end

   initial begin
      int  frame_len;
      int  count;
      bit  resized;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // A partial frame under the reset settings, cut short by the resize below.
      queue_scene(250, pick_spread());
      wait_idle();

      write_register(ddf_pkg::CSR_DEPTH_THRESHOLD, ddf_pkg::FAR_CODE);
      write_register(ddf_pkg::CSR_FRAME_WIDTH, csr_word_type'(3));
      write_register(ddf_pkg::CSR_FRAME_HEIGHT, csr_word_type'(2));
      queue_beat(24'h000005, 1'b0);
      queue_beat(24'hFFFFFE, 1'b0);
      queue_beat(24'hABCDEF, 1'b1);
      queue_beat(24'h000001, 1'b0);
      queue_beat(24'h000000, 1'b0);
      queue_beat(ddf_pkg::FAR_CODE, 1'b0);
      queue_beat(24'h800000, 1'b0);
      queue_beat(24'h0F0F0F, 1'b1);
      queue_beat(24'h555555, 1'b0);
      queue_beat(24'hFFFFFF, 1'b1);
      wait_idle();

      write_register(ddf_pkg::CSR_DEPTH_THRESHOLD, '0);
      write_register(ddf_pkg::CSR_FRAME_WIDTH, csr_word_type'(2));
      write_register(ddf_pkg::CSR_FRAME_HEIGHT, csr_word_type'(1));
      queue_beat(24'h000007, 1'b0);
      queue_beat(24'h000007, 1'b0);
      queue_beat(24'h000000, 1'b1);
      queue_beat(24'h000000, 1'b1);
      queue_beat(24'h000007, 1'b0);
      queue_beat(24'h000008, 1'b0);
      queue_beat(24'h000000, 1'b1);
      queue_beat(24'h000000, 1'b1);
      wait_idle();

      write_register(ddf_pkg::CSR_FRAME_WIDTH, csr_word_type'(1));
      queue_beat(24'h000001, 1'b0);
      queue_beat(24'h000000, 1'b1);
      wait_idle();

      // Widest row with a zero height, then the tallest column.
      write_register(ddf_pkg::CSR_DEPTH_THRESHOLD,
                     ddf_pkg::depth_code_type'($urandom_range(0, 4000)));
      write_register(ddf_pkg::CSR_FRAME_HEIGHT, csr_word_type'(0));
      write_register(ddf_pkg::CSR_FRAME_WIDTH,
                     csr_word_type'(($urandom_range(0, 1) != 0) ? 256 :
                                    $urandom_range(257, 511)));
      queue_scene(active_width() * (active_height() + 1), pick_spread());
      wait_idle();
      write_register(ddf_pkg::CSR_FRAME_WIDTH, csr_word_type'(1));
      write_register(ddf_pkg::CSR_FRAME_HEIGHT,
                     csr_word_type'(($urandom_range(0, 1) != 0) ? 256 :
                                    $urandom_range(257, 511)));
      queue_scene(active_width() * (active_height() + 1), pick_spread());
      wait_idle();
      phase_count = 5;

      resized = 1'b0;
      while (beats_counted < BEAT_TARGET) begin
         phase_count++;
         write_register(ddf_pkg::CSR_DEPTH_THRESHOLD, pick_threshold());
         if (!resized || $urandom_range(0, 4) != 0) begin
            resized = 1'b1;
            if ($urandom_range(0, 1) != 0) begin
               write_register(ddf_pkg::CSR_FRAME_HEIGHT,
                              csr_word_type'(($urandom_range(0, 9) == 0) ? 0 :
                                             $urandom_range(1, 6)));
               write_register(ddf_pkg::CSR_FRAME_WIDTH,
                              csr_word_type'(($urandom_range(0, 9) == 0) ? 0 :
                                             $urandom_range(1, 12)));
            end else begin
               write_register(ddf_pkg::CSR_FRAME_WIDTH,
                              csr_word_type'(($urandom_range(0, 9) == 0) ? 0 :
                                             $urandom_range(1, 12)));
               write_register(ddf_pkg::CSR_FRAME_HEIGHT,
                              csr_word_type'(($urandom_range(0, 9) == 0) ? 0 :
                                             $urandom_range(1, 6)));
            end
         end
         frame_len = active_width() * (active_height() + 1);
         count     = frame_len * $urandom_range(1, 3);
         if ($urandom_range(0, 3) == 0) count += $urandom_range(1, frame_len);
         queue_scene(count, pick_spread());
         wait_idle();
      end

      $display("Run covered %0d counted beats over %0d setting phases; %0d pixels checked.",
               beats_counted, phase_count, pixels_checked);
      $display({"Settings included zero and full-scale thresholds, saturated sizes",
                " and single rows."});
      if (mismatches == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("%0d pixel mismatches in total.", mismatches);
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/ddf_pkg.sv
hw/rtl/ddf_line_mem.sv
hw/rtl/ddf_judge.sv
hw/rtl/depth_discontinuity_filter_core.sv
bench/tb_top.sv
